// ===== design/rvc_pkg.sv =====
// Shared types and constants for the repeated value counter.
// Used by the channel interfaces, the controller, the datapath and the top level.
package rvc_pkg;

  localparam int unsigned MAX_DISTINCT = 64;
  localparam int unsigned IDX_W        = $clog2(MAX_DISTINCT);
  localparam int unsigned FILL_W       = $clog2(MAX_DISTINCT + 1);
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned DUP_W        = 6;

  localparam logic [DUP_W-1:0]  DUP_MAX  = {DUP_W{1'b1}};
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_DISTINCT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } rvc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } rvc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic scan_end;
    logic out_free;
  } rvc_status_t;

endpackage

// ===== design/rvc_in_if.sv =====
// Input channel of the repeated value counter: valid/ready plus one request.
// Depends on rvc_pkg for the field widths.
interface rvc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [rvc_pkg::VALUE_W-1:0] value;
  logic                               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== design/rvc_out_if.sv =====
// Result channel of the repeated value counter: valid/ready plus one result.
// Depends on rvc_pkg for the field widths.
interface rvc_out_if;
  logic                      valid;
  logic                      ready;
  logic [rvc_pkg::DUP_W-1:0] dup_count;
  logic                      overflow;
  logic                      final_res;

  modport source (output valid, output dup_count, output overflow, output final_res,
                  input ready);
  modport sink   (input valid, input dup_count, input overflow, input final_res,
                  output ready);
endinterface

// ===== design/repeated_value_counter_core.sv =====
// Top level of the repeated value counter: controller plus datapath.
// Depends on rvc_pkg, rvc_in_if, rvc_out_if, rvc_ctrl and rvc_datapath.
//
// The block takes one request at a time on in_i and returns one result on
// out_o for each: the number of distinct values seen two or more times so
// far in the current sequence (saturating at 63), an overflow flag that is
// set once a new distinct value could not be stored because all 64 table
// entries were in use, and final_res, which echoes the request's last flag.
// After the result of a request marked last, the table, count and overflow
// flag are cleared, so the next request starts a new sequence. Each request
// is compared against the stored distinct values one entry per cycle through
// the single read port of the value table, up to the number of entries in
// use; a match ends the scan early. The result sits in an output register,
// so a result waiting to be taken does not hold up the scan of the next
// request, only its final commit. There is no clearing pass after reset.
module repeated_value_counter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  rvc_in_if.sink    in_i,
  rvc_out_if.source out_o
);

  rvc_pkg::rvc_cmd_t    cmd;
  rvc_pkg::rvc_status_t status;

  // The controller sequences accept, scan and commit of each request.
  rvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the table, the marks, the count and the result register.
  rvc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .last_i      (in_i.last),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .dup_count_o (out_o.dup_count),
    .overflow_o  (out_o.overflow),
    .final_res_o (out_o.final_res)
  );

endmodule

// ===== design/rvc_ctrl.sv =====
// Controller state machine of the repeated value counter.
// Depends on rvc_pkg for the state enum and the command and status structs.
module rvc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rvc_pkg::rvc_status_t status_i,
  output rvc_pkg::rvc_cmd_t    cmd_o
);

  rvc_pkg::rvc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rvc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rvc_pkg::S_IDLE: begin
        if (in_valid_i) state_d = rvc_pkg::S_SCAN;
      end
      rvc_pkg::S_SCAN: begin
        if (status_i.match || status_i.scan_end) state_d = rvc_pkg::S_DONE;
      end
      rvc_pkg::S_DONE: begin
        if (status_i.out_free) state_d = rvc_pkg::S_IDLE;
      end
      default: state_d = rvc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      rvc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rvc_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      rvc_pkg::S_DONE: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/rvc_datapath.sv =====
// Datapath of the repeated value counter: value table memory, scan pipeline,
// counted marks, running count and the result register. Depends on rvc_pkg.
module rvc_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [rvc_pkg::VALUE_W-1:0] value_i,
  input  logic                               last_i,
  input  rvc_pkg::rvc_cmd_t                  cmd_i,
  output rvc_pkg::rvc_status_t               status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rvc_pkg::DUP_W-1:0]          dup_count_o,
  output logic                               overflow_o,
  output logic                               final_res_o
);

  // Table of distinct values; entries below fill_q are in use.
  logic [rvc_pkg::VALUE_W-1:0]      mem_q [rvc_pkg::MAX_DISTINCT];
  logic [rvc_pkg::VALUE_W-1:0]      rd_data_q;

  logic [rvc_pkg::VALUE_W-1:0]      value_q;
  logic                             last_q;
  logic [rvc_pkg::FILL_W-1:0]       fill_q;
  logic [rvc_pkg::FILL_W-1:0]       rd_idx_q;
  logic                             cmp_valid_q;
  logic [rvc_pkg::IDX_W-1:0]        cmp_idx_q;
  logic                             hit_q;
  logic [rvc_pkg::IDX_W-1:0]        hit_idx_q;
  logic [rvc_pkg::MAX_DISTINCT-1:0] counted_q;
  logic [rvc_pkg::DUP_W-1:0]        total_q;
  logic                             ovf_q;
  logic                             out_valid_q;
  logic [rvc_pkg::DUP_W-1:0]        out_dup_q;
  logic                             out_ovf_q;
  logic                             out_final_q;

  logic                             issue;
  logic                             insert;
  logic [rvc_pkg::DUP_W-1:0]        total_d;
  logic                             ovf_d;

  assign issue  = cmd_i.scan && (rd_idx_q != fill_q);
  assign insert = !hit_q && (fill_q != rvc_pkg::FILL_MAX);

  assign status_o.match    = cmd_i.scan && cmp_valid_q && (rd_data_q == value_q);
  assign status_o.scan_end = (rd_idx_q == fill_q) && !cmp_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    total_d = total_q;
    if (hit_q && !counted_q[hit_idx_q] && (total_q != rvc_pkg::DUP_MAX)) begin
      total_d = total_q + rvc_pkg::DUP_W'(1);
    end
    ovf_d = ovf_q | (!hit_q && !insert);
  end

  // Table with one read and one write port: one registered read and one write per cycle.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_idx_q[rvc_pkg::IDX_W-1:0]];
    if (cmd_i.commit && insert) begin
      mem_q[fill_q[rvc_pkg::IDX_W-1:0]] <= value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rd_idx_q    <= '0;
      cmp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      counted_q   <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_idx_q    <= '0;
        cmp_valid_q <= 1'b0;
        hit_q       <= 1'b0;
      end else if (cmd_i.scan) begin
        if (issue) rd_idx_q <= rd_idx_q + rvc_pkg::FILL_W'(1);
        cmp_valid_q <= issue;
        if (status_o.match) hit_q <= 1'b1;
      end

      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          fill_q    <= '0;
          counted_q <= '0;
          total_q   <= '0;
          ovf_q     <= 1'b0;
        end else begin
          total_q <= total_d;
          ovf_q   <= ovf_d;
          if (hit_q) counted_q[hit_idx_q] <= 1'b1;
          if (insert) fill_q <= fill_q + rvc_pkg::FILL_W'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
      last_q  <= last_i;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= rd_idx_q[rvc_pkg::IDX_W-1:0];
      if (status_o.match) hit_idx_q <= cmp_idx_q;
    end
    if (cmd_i.commit) begin
      out_dup_q   <= total_d;
      out_ovf_q   <= ovf_d;
      out_final_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dup_count_o = out_dup_q;
  assign overflow_o  = out_ovf_q;
  assign final_res_o = out_final_q;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= rvc_pkg::FILL_MAX)
    else $error("table fill level beyond its depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (rd_idx_q <= fill_q))
    else $error("scan read index ran past the fill level");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over an unread result");

  a_rise_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit))
    else $error("result appeared without a commit");
`endif

endmodule
